/* sv/crc_chg_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the autosave controller.
package crc_chg_pkg;

    localparam int unsigned TICK_WIDTH_DEF = 32;
    localparam int unsigned CFG_W          = 16;
    localparam int unsigned CFG_IDX_W      = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [15:0] CHECK_PERIOD_RST   = 16'd250;
    localparam logic [15:0] DEBOUNCE_DELAY_RST = 16'd2000;
    localparam logic [15:0] MIN_WRITE_GAP_RST  = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WRITE_GAP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_ATTACHED   = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CHECK = 2'd1,
        OP_BASE  = 2'd2,
        OP_FLUSH = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [15:0] check_period;
        logic [15:0] debounce_delay;
        logic [15:0] min_write_gap;
        logic        ram_attached;
    } t_cfg;

    // events from the CRC side that touch the schedule
    typedef struct packed {
        logic arm;     // check scan found a change: arm debounce deadline
        logic rebase;  // baseline scan finished: clear schedule and deadline
    } t_crc_evt;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

endpackage

/* sv/crc_change_debounced_autosave_core.sv */
// Autosave controller: with the RAM attached, a tick beat with the current
// time asks for a RAM scan when a check is due and flushes once a debounce
// deadline and the minimum write gap have passed, and a flush beat flushes.
// Scan beats fold one byte each into a reflected CRC-32 that is compared with
// the stored CRC on the last byte of a check scan. One beat is accepted every
// cycle while results are taken; it passes from the input register to the
// result register through the single stage that holds the byte-wide CRC update
// and the time compares. A stalled result does not stop intake until the input
// register is also full. Write configuration only while no beat is in flight.
module crc_change_debounced_autosave_core #(
    parameter int unsigned TICK_WIDTH = crc_chg_pkg::TICK_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crc_chg_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [crc_chg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [31:0]                       i_now,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_scan_request,
    output logic                              o_flush,
    output logic                              o_changed,
    output logic [31:0]                       o_crc_value
);

    crc_chg_pkg::t_cfg r_cfg;

    logic                  r_in_vld;
    crc_chg_pkg::t_opcode  r_in_op;
    logic [TICK_WIDTH-1:0] r_in_now;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;

    logic                  r_out_vld;
    logic                  r_out_scan;
    logic                  r_out_flush;
    logic                  r_out_changed;
    logic [31:0]           r_out_crc;

    logic                  w_adv;
    logic                  w_take;
    logic [TICK_WIDTH+31:0] w_now_x;
    logic [31:0]           w_crc;
    logic                  w_changed;
    logic                  w_scan;
    logic                  w_flush;
    crc_chg_pkg::t_crc_evt w_evt;

    // time is taken modulo 2^TICK_WIDTH
    assign w_now_x = {{TICK_WIDTH{1'b0}}, i_now};

    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_period   <= crc_chg_pkg::CHECK_PERIOD_RST;
            r_cfg.debounce_delay <= crc_chg_pkg::DEBOUNCE_DELAY_RST;
            r_cfg.min_write_gap  <= crc_chg_pkg::MIN_WRITE_GAP_RST;
            r_cfg.ram_attached   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                crc_chg_pkg::REG_CHECK_PERIOD:   r_cfg.check_period   <= i_cfg_data;
                crc_chg_pkg::REG_DEBOUNCE_DELAY: r_cfg.debounce_delay <= i_cfg_data;
                crc_chg_pkg::REG_MIN_WRITE_GAP:  r_cfg.min_write_gap  <= i_cfg_data;
                crc_chg_pkg::REG_RAM_ATTACHED:   r_cfg.ram_attached   <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_op   <= crc_chg_pkg::t_opcode'(i_opcode);
            r_in_now  <= w_now_x[TICK_WIDTH-1:0];
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    crc_chg_crc u_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (w_adv),
        .i_op        (r_in_op),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_crc_value (w_crc),
        .o_changed   (w_changed),
        .o_evt       (w_evt)
    );

    crc_chg_sched #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_sched (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_proc         (w_adv),
        .i_op           (r_in_op),
        .i_now          (r_in_now),
        .i_cfg          (r_cfg),
        .i_evt          (w_evt),
        .o_scan_request (w_scan),
        .o_flush        (w_flush)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_scan    <= w_scan;
            r_out_flush   <= w_flush;
            r_out_changed <= w_changed;
            r_out_crc     <= w_crc;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_scan_request = r_out_scan;
    assign o_flush        = r_out_flush;
    assign o_changed      = r_out_changed;
    assign o_crc_value    = r_out_crc;

endmodule

/* sv/crc_chg_crc.sv */
// Running and stored CRC-32, change detection on the last scan beat.
module crc_chg_crc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_proc,
    input  crc_chg_pkg::t_opcode i_op,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic [31:0]          o_crc_value,
    output logic                 o_changed,
    output crc_chg_pkg::t_crc_evt o_evt
);

    logic [31:0] r_running, n_running;
    logic [31:0] r_stored, n_stored;
    logic        w_scan;
    logic [31:0] w_upd;
    logic [31:0] w_fin;

    assign w_scan = (i_op == crc_chg_pkg::OP_CHECK) || (i_op == crc_chg_pkg::OP_BASE);
    assign w_upd  = crc_chg_pkg::crc_byte(r_running, i_byte);
    assign w_fin  = w_upd ^ crc_chg_pkg::CRC_ONES;

    always_comb begin
        n_running   = r_running;
        n_stored    = r_stored;
        o_crc_value = r_stored;
        o_changed   = 1'b0;
        o_evt       = '0;
        if (w_scan) begin
            n_running = w_upd;
            if (i_last) begin
                n_running   = crc_chg_pkg::CRC_ONES;
                o_crc_value = w_fin;
                if (i_op == crc_chg_pkg::OP_CHECK) begin
                    if (w_fin != r_stored) begin
                        n_stored  = w_fin;
                        o_changed = 1'b1;
                        o_evt.arm = 1'b1;
                    end
                end else begin
                    n_stored     = w_fin;
                    o_evt.rebase = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= crc_chg_pkg::CRC_ONES;
            r_stored  <= '0;
        end else if (i_proc) begin
            r_running <= n_running;
            r_stored  <= n_stored;
        end
    end

endmodule

/* sv/crc_chg_sched.sv */
// Check schedule, debounce deadline and write-gap tracking.
module crc_chg_sched #(
    parameter int unsigned TICK_WIDTH = crc_chg_pkg::TICK_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_proc,
    input  crc_chg_pkg::t_opcode  i_op,
    input  logic [TICK_WIDTH-1:0] i_now,
    input  crc_chg_pkg::t_cfg     i_cfg,
    input  crc_chg_pkg::t_crc_evt i_evt,
    output logic                  o_scan_request,
    output logic                  o_flush
);

    logic [TICK_WIDTH-1:0] r_next_check, n_next_check;
    logic [TICK_WIDTH-1:0] r_check_start, n_check_start;
    logic [TICK_WIDTH-1:0] r_deadline, n_deadline;
    logic                  r_pending, n_pending;
    logic [TICK_WIDTH-1:0] r_next_write, n_next_write;

    logic [TICK_WIDTH+15:0] w_period_x, w_delay_x, w_gap_x;
    logic [TICK_WIDTH-1:0]  w_period, w_delay, w_gap;

    // zero-extend 16-bit settings to tick width (TICK_WIDTH >= 16)
    assign w_period_x = {{TICK_WIDTH{1'b0}}, i_cfg.check_period};
    assign w_delay_x  = {{TICK_WIDTH{1'b0}}, i_cfg.debounce_delay};
    assign w_gap_x    = {{TICK_WIDTH{1'b0}}, i_cfg.min_write_gap};
    assign w_period   = w_period_x[TICK_WIDTH-1:0];
    assign w_delay    = w_delay_x[TICK_WIDTH-1:0];
    assign w_gap      = w_gap_x[TICK_WIDTH-1:0];

    always_comb begin
        n_next_check   = r_next_check;
        n_check_start  = r_check_start;
        n_deadline     = r_deadline;
        n_pending      = r_pending;
        n_next_write   = r_next_write;
        o_scan_request = 1'b0;
        o_flush        = 1'b0;
        unique case (i_op)
            crc_chg_pkg::OP_TICK: begin
                if (i_cfg.ram_attached) begin
                    if (i_now >= r_next_check) begin
                        n_next_check   = i_now + w_period;
                        n_check_start  = i_now;
                        o_scan_request = 1'b1;
                    end
                    if (r_pending && (i_now >= r_deadline)) begin
                        if (i_now >= r_next_write) begin
                            o_flush      = 1'b1;
                            n_next_write = i_now + w_gap;
                        end
                        n_pending = 1'b0;
                    end
                end
            end
            crc_chg_pkg::OP_FLUSH: begin
                o_flush = i_cfg.ram_attached;
            end
            crc_chg_pkg::OP_CHECK,
            crc_chg_pkg::OP_BASE: begin
                // deadline counts from the tick that started the check
                if (i_evt.arm) begin
                    n_deadline = r_check_start + w_delay;
                    n_pending  = 1'b1;
                end
                if (i_evt.rebase) begin
                    n_next_check = '0;
                    n_deadline   = '0;
                    n_pending    = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_check  <= '0;
            r_check_start <= '0;
            r_deadline    <= '0;
            r_pending     <= 1'b0;
            r_next_write  <= '0;
        end else if (i_proc) begin
            r_next_check  <= n_next_check;
            r_check_start <= n_check_start;
            r_deadline    <= n_deadline;
            r_pending     <= n_pending;
            r_next_write  <= n_next_write;
        end
    end

endmodule

/* tb/sv/crc_change_debounced_autosave_core_tb.sv */
// Self-checking testbench for the CRC change-detect autosave controller core.
module crc_change_debounced_autosave_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 300;

    typedef struct {
        crc_chg_pkg::t_opcode op;
        logic [31:0]          now;
        logic [7:0]           data;
        logic                 last;
    } t_beat;

    typedef struct {
        logic        scan;
        logic        flush;
        logic        changed;
        logic [31:0] crc;
    } t_autosave_res;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [crc_chg_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [crc_chg_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [1:0]                        i_opcode = '0;
    logic [31:0]                       i_now = '0;
    logic [7:0]                        i_data_byte = '0;
    logic                              i_last_byte = 1'b0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic                              o_scan_request;
    logic                              o_flush;
    logic                              o_changed;
    logic [31:0]                       o_crc_value;

    crc_change_debounced_autosave_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_now          (i_now),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_scan_request (o_scan_request),
        .o_flush        (o_flush),
        .o_changed      (o_changed),
        .o_crc_value    (o_crc_value)
    );

    // configuration shadow
    logic [15:0] cfg_period, cfg_debounce, cfg_gap;
    logic        cfg_attached;

    // predicted controller state
    logic [31:0] crc_acc, crc_saved, check_due, check_origin, flush_due, write_ok_at;
    logic        flush_armed;

    t_beat         beat_q[$];
    t_autosave_res result_q[$];
    t_beat         cur_beat;
    int            n_queued = 0;
    int            n_accepted = 0;
    int            err_cnt = 0;
    int            cycle_cnt = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          stall_kick = 1'b0;
    int            stall_left = 0;

    // stimulus-side view of the save RAM and wall time
    logic [7:0]  ram_img[8];
    int          img_len = 4;
    logic [31:0] clock_now = '0;
    int          step_span = 20;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] s;
        s = c ^ {24'd0, b};
        repeat (8) s = (s >> 1) ^ (crc_chg_pkg::CRC_POLY & {32{s[0]}});
        return s;
    endfunction

    function automatic t_autosave_res predict_result(input t_beat b);
        t_autosave_res r;
        logic [31:0]   fin;
        r.scan    = 1'b0;
        r.flush   = 1'b0;
        r.changed = 1'b0;
        r.crc     = crc_saved;
        unique case (b.op)
            crc_chg_pkg::OP_TICK: begin
                if (cfg_attached) begin
                    if (b.now >= check_due) begin
                        check_due    = b.now + {16'd0, cfg_period};
                        check_origin = b.now;
                        r.scan       = 1'b1;
                    end
                    if (flush_armed && b.now >= flush_due) begin
                        if (b.now >= write_ok_at) begin
                            r.flush     = 1'b1;
                            write_ok_at = b.now + {16'd0, cfg_gap};
                        end
                        flush_armed = 1'b0;
                    end
                end
            end
            crc_chg_pkg::OP_FLUSH: r.flush = cfg_attached;
            default: begin
                crc_acc = crc_fold(crc_acc, b.data);
                if (b.last) begin
                    fin     = ~crc_acc;
                    crc_acc = crc_chg_pkg::CRC_ONES;
                    r.crc   = fin;
                    if (b.op == crc_chg_pkg::OP_CHECK) begin
                        if (fin != crc_saved) begin
                            crc_saved   = fin;
                            flush_due   = check_origin + {16'd0, cfg_debounce};
                            flush_armed = 1'b1;
                            r.changed   = 1'b1;
                        end
                    end else begin
                        crc_saved   = fin;
                        check_due   = '0;
                        flush_due   = '0;
                        flush_armed = 1'b0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                result_q.push_back(predict_result(cur_beat));
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_beat = beat_q.pop_front();
                    i_valid     <= 1'b1;
                    i_opcode    <= cur_beat.op;
                    i_now       <= cur_beat.now;
                    i_data_byte <= cur_beat.data;
                    i_last_byte <= cur_beat.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_autosave_res e;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with no expectation pending");
                    err_cnt++;
                end else begin
                    e = result_q.pop_front();
                    if (o_scan_request !== e.scan) begin
                        $error("scan_request: expected %0b, actual %0b", e.scan, o_scan_request);
                        err_cnt++;
                    end
                    if (o_flush !== e.flush) begin
                        $error("flush: expected %0b, actual %0b", e.flush, o_flush);
                        err_cnt++;
                    end
                    if (o_changed !== e.changed) begin
                        $error("changed: expected %0b, actual %0b", e.changed, o_changed);
                        err_cnt++;
                    end
                    if (o_crc_value !== e.crc) begin
                        $error("crc_value: expected %08h, actual %08h", e.crc, o_crc_value);
                        err_cnt++;
                    end
                end
            end
            if (stall_kick) begin
                stall_left <= LONG_STALL;
                i_ready    <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_beat(input crc_chg_pkg::t_opcode op, input logic [31:0] now,
                             input logic [7:0] data, input logic last);
        t_beat b;
        b.op   = op;
        b.now  = now;
        b.data = data;
        b.last = last;
        beat_q.push_back(b);
        n_queued++;
    endtask

    task automatic push_scan(input crc_chg_pkg::t_opcode op);
        for (int k = 0; k < img_len; k++)
            push_beat(op, $urandom, ram_img[k], k == img_len - 1);
    endtask

    task automatic push_tick(input logic [31:0] now);
        push_beat(crc_chg_pkg::OP_TICK, now, 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [crc_chg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        case (idx)
            crc_chg_pkg::REG_CHECK_PERIOD:   cfg_period   = val;
            crc_chg_pkg::REG_DEBOUNCE_DELAY: cfg_debounce = val;
            crc_chg_pkg::REG_MIN_WRITE_GAP:  cfg_gap      = val;
            crc_chg_pkg::REG_RAM_ATTACHED:   cfg_attached = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] period, input logic [15:0] debounce,
                              input logic [15:0] gap, input logic attached);
        logic [14:0] junk;
        junk = 15'($urandom);
        cfg_write(crc_chg_pkg::REG_CHECK_PERIOD, period);
        cfg_write(crc_chg_pkg::REG_DEBOUNCE_DELAY, debounce);
        cfg_write(crc_chg_pkg::REG_MIN_WRITE_GAP, gap);
        // upper bits of the attach register are don't-care
        cfg_write(crc_chg_pkg::REG_RAM_ATTACHED, {junk, attached});
    endtask

    task automatic set_small_config();
        set_config(16'($urandom_range(1, 30)), 16'($urandom_range(1, 60)),
                   16'($urandom_range(0, 120)), 1'b1);
        step_span = $urandom_range(5, 40);
    endtask

    task automatic pulse_long_stall();
        @(posedge i_clk);
        stall_kick <= 1'b1;
        @(posedge i_clk);
        stall_kick <= 1'b0;
    endtask

    // mostly tick / check-scan / tick sequences, plus baselines, flushes and noise
    task automatic gen_session(input int n);
        int goal;
        int pick;
        int nb;
        goal = n_queued + n;
        while (n_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                clock_now += $urandom_range(0, step_span);
                push_tick(clock_now);
                if ($urandom_range(0, 1)) ram_img[$urandom_range(0, img_len - 1)] = 8'($urandom);
                push_scan(crc_chg_pkg::OP_CHECK);
                repeat ($urandom_range(1, 3)) begin
                    clock_now += $urandom_range(0, step_span);
                    push_tick(clock_now);
                end
            end else if (pick < 65) begin
                if ($urandom_range(0, 3) == 0) begin
                    img_len = $urandom_range(1, 8);
                    for (int k = 0; k < 8; k++) ram_img[k] = 8'($urandom);
                end
                push_scan(crc_chg_pkg::OP_BASE);
            end else if (pick < 72) begin
                push_beat(crc_chg_pkg::OP_FLUSH, $urandom, 8'($urandom), 1'($urandom));
            end else if (pick < 78) begin
                // time jump, often to just below the wrap point
                if ($urandom_range(0, 1))
                    clock_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * step_span);
                else
                    clock_now = $urandom;
                push_tick(clock_now);
            end else if (pick < 90) begin
                // broken or mixed scan: random opcode per byte, maybe no last byte
                nb = $urandom_range(1, 4);
                for (int k = 0; k < nb; k++)
                    push_beat($urandom_range(0, 1) ? crc_chg_pkg::OP_CHECK
                                                   : crc_chg_pkg::OP_BASE,
                              $urandom, 8'($urandom),
                              (k == nb - 1) && $urandom_range(0, 1));
            end else begin
                push_beat(crc_chg_pkg::t_opcode'($urandom_range(0, 3)), $urandom,
                          8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        cfg_period   = crc_chg_pkg::CHECK_PERIOD_RST;
        cfg_debounce = crc_chg_pkg::DEBOUNCE_DELAY_RST;
        cfg_gap      = crc_chg_pkg::MIN_WRITE_GAP_RST;
        cfg_attached = 1'b0;
        crc_acc      = crc_chg_pkg::CRC_ONES;
        crc_saved    = '0;
        check_due    = '0;
        check_origin = '0;
        flush_due    = '0;
        flush_armed  = 1'b0;
        write_ok_at  = '0;
        for (int k = 0; k < 8; k++) ram_img[k] = 8'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // detached RAM with reset settings
        push_tick(32'h0000_0000);
        push_tick(32'hFFFF_FFFF);
        push_beat(crc_chg_pkg::OP_FLUSH, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        push_beat(crc_chg_pkg::OP_CHECK, 32'h0, 8'hA5, 1'b1);
        push_beat(crc_chg_pkg::OP_BASE, 32'h0, 8'h00, 1'b0);
        push_beat(crc_chg_pkg::OP_BASE, 32'h0, 8'hFF, 1'b1);
        wait_idle();

        // tightest timing, no write gap
        set_config(16'd1, 16'd1, 16'd0, 1'b1);
        push_tick(32'd0);
        push_beat(crc_chg_pkg::OP_CHECK, 32'h0, 8'h00, 1'b0);
        push_beat(crc_chg_pkg::OP_CHECK, 32'h0, 8'hFF, 1'b1);
        push_tick(32'd0);
        push_tick(32'd1);
        push_beat(crc_chg_pkg::OP_CHECK, 32'h0, 8'h00, 1'b0);
        push_beat(crc_chg_pkg::OP_CHECK, 32'h0, 8'hFF, 1'b1);
        push_beat(crc_chg_pkg::OP_FLUSH, 32'h0, 8'h00, 1'b0);
        push_tick(32'hFFFF_FFFF);
        push_tick(32'd0);
        push_beat(crc_chg_pkg::OP_CHECK, 32'h0, 8'h12, 1'b0);
        push_beat(crc_chg_pkg::OP_BASE, 32'h0, 8'h34, 1'b1);
        push_beat(crc_chg_pkg::OP_BASE, 32'h0, 8'h56, 1'b0);
        push_beat(crc_chg_pkg::OP_CHECK, 32'h0, 8'h78, 1'b1);
        push_beat(crc_chg_pkg::OP_TICK, 32'd5, 8'hFF, 1'b1);
        push_beat(crc_chg_pkg::OP_TICK, 32'h0000_FFFF, 8'h00, 1'b0);
        push_beat(crc_chg_pkg::OP_BASE, 32'hAAAA_5555, 8'h80, 1'b1);
        wait_idle();

        // back-to-back with a long receiver hold-off
        set_small_config();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gen_session(130);
        pulse_long_stall();
        wait_idle();

        // largest settings, sender gaps, one full drain in the middle
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        step_span      = 70000;
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        gen_session(55);
        wait_idle();
        gen_session(55);
        wait_idle();

        set_small_config();
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        gen_session(130);
        wait_idle();

        set_config(16'd1, 16'd1, 16'd0, 1'b1);
        step_span      = 3;
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        gen_session(130);
        wait_idle();

        set_small_config();
        cfg_write(crc_chg_pkg::REG_RAM_ATTACHED, 16'h0000);
        gen_session(30);
        wait_idle();

        set_small_config();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        gen_session(100);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d expected results never arrived", result_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
sv/crc_chg_pkg.sv
sv/crc_chg_crc.sv
sv/crc_chg_sched.sv
sv/crc_change_debounced_autosave_core.sv
tb/sv/crc_change_debounced_autosave_core_tb.sv
